[rtl/core/btpr_pkg.sv]
// ----------------------------------------------------------------------------
// BER-TLV primitive reader package
// Shared payload types, register indexes, status codes and byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package btpr_pkg;

	localparam int TAG_BITS_DEF = 16;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPECTED_TAG     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VALUE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXACT_MODE       = 2'd2;

	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_OK        = 3'd1;
	localparam logic [2:0] ST_BAD_TAG   = 3'd2;
	localparam logic [2:0] ST_TOO_LONG  = 3'd3;
	localparam logic [2:0] ST_NOT_EXACT = 3'd4;

	localparam logic [4:0] TAG_EXT_CODE = 5'h1F;
	localparam logic [7:0] LEN_LONG_FORM = 8'h80;
	localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_flag;
	} btpr_in_t;

	typedef struct packed {
		logic [7:0]  value_byte;
		logic        value_valid;
		logic        element_done;
		logic [2:0]  status;
		logic [15:0] value_length;
		logic [15:0] consumed_bytes;
	} btpr_out_t;

endpackage

`default_nettype wire

[rtl/core/ber_tlv_primitive_reader.sv]
// ----------------------------------------------------------------------------
// BER-TLV primitive reader
// Parses one BER-TLV element a byte at a time, checks its tag and length,
// and passes the value bytes out with a final status item.
//
// The block takes one encoded byte per clock cycle while its output is not
// held back, and returns one result item for every byte it takes. A byte
// passes an input register and then the tag, length and value update, which
// writes the element state and the result register in the same cycle, once
// the result register is free or being emptied.
// The input register and the result register let a new byte enter while an
// earlier result still waits. Configuration writes are always ready and
// should be made only while no element item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_tlv_primitive_reader #(
	parameter int TAG_BITS = btpr_pkg::TAG_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [btpr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [btpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  btpr_pkg::btpr_in_t            in_data,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output btpr_pkg::btpr_out_t                 out_data
);

	localparam int CMP_BITS = (TAG_BITS > 16) ? TAG_BITS : 16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TAG_MORE,
		PH_LEN_HEAD,
		PH_LEN_MORE,
		PH_VALUE,
		PH_DONE
	} phase_t;

	logic [15:0]         expected_tag_q;
	logic [15:0]         max_value_length_q;
	logic                exact_mode_q;

	logic                valid_s1;
	btpr_pkg::btpr_in_t  data_s1;
	logic                out_valid_s2;
	btpr_pkg::btpr_out_t out_data_s2;

	phase_t              phase_q, phase_n;
	logic [TAG_BITS-1:0] tag_accum_q, tag_accum_n;
	logic [15:0]         length_accum_q, length_accum_n;
	logic [6:0]          length_left_q, length_left_n;
	logic [15:0]         value_left_q, value_left_n;
	logic [15:0]         byte_offset_q, byte_offset_n;

	logic                advance;
	logic                tag_fin;
	logic                len_fin;
	logic [7:0]          b;
	btpr_pkg::btpr_out_t res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;
	assign b         = data_s1.data_byte;

	always_comb begin
		phase_n        = phase_q;
		tag_accum_n    = tag_accum_q;
		length_accum_n = length_accum_q;
		length_left_n  = length_left_q;
		value_left_n   = value_left_q;
		byte_offset_n  = byte_offset_q;
		res            = '0;
		tag_fin        = 1'b0;
		len_fin        = 1'b0;

		if (data_s1.start_flag) begin
			byte_offset_n  = 16'd1;
			tag_accum_n    = TAG_BITS'(b);
			length_accum_n = '0;
			length_left_n  = '0;
			value_left_n   = '0;
			if (b[4:0] == btpr_pkg::TAG_EXT_CODE) begin
				phase_n = PH_TAG_MORE;
			end else begin
				tag_fin = 1'b1;
			end
		end else if (phase_q == PH_TAG_MORE || phase_q == PH_LEN_HEAD ||
				phase_q == PH_LEN_MORE || phase_q == PH_VALUE) begin
			byte_offset_n = byte_offset_q + 16'd1;
			case (phase_q)
				PH_TAG_MORE: begin
					tag_accum_n = TAG_BITS'({tag_accum_q, b});
					tag_fin     = !b[7];
				end
				PH_LEN_HEAD: begin
					if (b[7] && (b[6:0] & btpr_pkg::LEN_COUNT_MASK) != 7'd0) begin
						length_accum_n = '0;
						length_left_n  = b[6:0];
						phase_n        = PH_LEN_MORE;
					end else begin
						length_accum_n = (b >= btpr_pkg::LEN_LONG_FORM) ? 16'd0 : {8'd0, b};
						len_fin        = 1'b1;
					end
				end
				PH_LEN_MORE: begin
					length_accum_n = {length_accum_q[7:0], b};
					length_left_n  = length_left_q - 7'd1;
					len_fin        = (length_left_n == 7'd0);
				end
				default: begin
					res.value_byte   = b;
					res.value_valid  = 1'b1;
					res.value_length = length_accum_q;
					value_left_n     = value_left_q - 16'd1;
					if (value_left_n == 16'd0) begin
						res.element_done   = 1'b1;
						res.status         = btpr_pkg::ST_OK;
						res.consumed_bytes = byte_offset_n;
						phase_n            = PH_DONE;
					end
				end
			endcase
		end

		if (tag_fin) begin
			if (CMP_BITS'(tag_accum_n) != CMP_BITS'(expected_tag_q)) begin
				res.element_done = 1'b1;
				res.status       = btpr_pkg::ST_BAD_TAG;
				phase_n          = PH_DONE;
			end else begin
				phase_n = PH_LEN_HEAD;
			end
		end

		if (len_fin) begin
			res.value_length = length_accum_n;
			if (exact_mode_q && length_accum_n != max_value_length_q) begin
				res.element_done = 1'b1;
				res.status       = btpr_pkg::ST_NOT_EXACT;
				phase_n          = PH_DONE;
			end else if (length_accum_n > max_value_length_q) begin
				res.element_done = 1'b1;
				res.status       = btpr_pkg::ST_TOO_LONG;
				phase_n          = PH_DONE;
			end else if (length_accum_n == 16'd0) begin
				res.element_done   = 1'b1;
				res.status         = btpr_pkg::ST_OK;
				res.consumed_bytes = byte_offset_n;
				phase_n            = PH_DONE;
			end else begin
				value_left_n = length_accum_n;
				phase_n      = PH_VALUE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tag_q     <= '0;
			max_value_length_q <= '0;
			exact_mode_q       <= 1'b0;
			valid_s1           <= 1'b0;
			out_valid_s2       <= 1'b0;
			phase_q            <= PH_IDLE;
			tag_accum_q        <= '0;
			length_accum_q     <= '0;
			length_left_q      <= '0;
			value_left_q       <= '0;
			byte_offset_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					btpr_pkg::CFG_EXPECTED_TAG:     expected_tag_q     <= cfg_data;
					btpr_pkg::CFG_MAX_VALUE_LENGTH: max_value_length_q <= cfg_data;
					btpr_pkg::CFG_EXACT_MODE:       exact_mode_q       <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
				if (in_valid) begin
					data_s1 <= in_data;
				end
			end
			if (advance) begin
				out_valid_s2   <= 1'b1;
				out_data_s2    <= res;
				phase_q        <= phase_n;
				tag_accum_q    <= tag_accum_n;
				length_accum_q <= length_accum_n;
				length_left_q  <= length_left_n;
				value_left_q   <= value_left_n;
				byte_offset_q  <= byte_offset_n;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (out_data_s2.element_done ==
			(out_data_s2.status != btpr_pkg::ST_BUSY)))
		else $error("status and element_done disagree");

	a_value_phase_copies: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !data_s1.start_flag && phase_q == PH_VALUE)
		|=> (out_valid_s2 && out_data_s2.value_valid))
		else $error("value byte not passed out");

	a_consumed_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && out_data_s2.consumed_bytes != 16'd0)
		|-> (out_data_s2.status == btpr_pkg::ST_OK))
		else $error("byte count given without ok status");
`endif

endmodule

`default_nettype wire
